@@ rtl/core/mss_pkg.sv @@
// mss_pkg: command codes, field widths and the controller command bundle
// shared by the multi-stack store controller, datapath and top level
// no dependencies
`timescale 1ns / 1ps

package mss_pkg;

    localparam int CMD_W = 2;
    localparam int SID_W = 3;
    localparam int VAL_W = 32;

    // s_tdata carries cmd, stack_id, push_value; m_tdata carries
    // ok, top_value, stack_empty, store_full, both padded to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;
    // unused code: changes nothing and reports the addressed stack
    localparam logic [CMD_W-1:0] CMD_RSVD = 2'd3;

    typedef struct packed {
        logic accept;    // latch the input transfer and start the link read
        logic update;    // apply list updates and start the value read
        logic load_out;  // move the pending result into the output register
    } mss_ctrl_t;

endpackage

@@ rtl/core/mss_ram.sv @@
// mss_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
`timescale 1ns / 1ps

module mss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/mss_datapath.sv @@
// mss_datapath: stack heads, free-list head, fill counter, link and value rams,
// pending result and output register
// depends on mss_pkg and mss_ram
`timescale 1ns / 1ps

module mss_datapath import mss_pkg::*; #(
    parameter int SLOT_COUNT = 16,
    parameter int STACK_COUNT = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  mss_ctrl_t               ctrl,
    input  logic [CMD_W-1:0]        in_cmd,
    input  logic [SID_W-1:0]        in_stack_id,
    input  logic signed [VAL_W-1:0] in_push_value,
    output logic                    out_ok,
    output logic signed [VAL_W-1:0] out_top_value,
    output logic                    out_stack_empty,
    output logic                    out_store_full
);

    localparam int PTR_W = $clog2(SLOT_COUNT + 1);
    localparam int ADDR_W = $clog2(SLOT_COUNT);
    localparam int SID_SPAN = 2 ** SID_W;
    localparam int HEAD_DEPTH = (STACK_COUNT < SID_SPAN) ? STACK_COUNT : SID_SPAN;
    localparam int HIDX_W = (HEAD_DEPTH > 1) ? $clog2(HEAD_DEPTH) : 1;
    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(SLOT_COUNT);

    // list state
    logic [PTR_W-1:0] heads_reg [HEAD_DEPTH];
    logic [PTR_W-1:0] free_head_reg, free_head_next;
    // slots at or above fill_reg were never taken and still link to their successor
    logic [PTR_W-1:0] fill_reg, fill_next;

    // latched operation
    logic [CMD_W-1:0]        op_reg;
    logic                    sid_ok_reg;
    logic [HIDX_W-1:0]       hidx_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic [PTR_W-1:0]        head_reg;
    logic [PTR_W-1:0]        link_addr_reg;
    logic                    link_fresh_reg;

    // pending result
    logic ok_p_reg, empty_p_reg, full_p_reg, use_val_p_reg;

    // output register
    logic                    m_ok_reg;
    logic signed [VAL_W-1:0] m_top_reg;
    logic                    m_empty_reg;
    logic                    m_full_reg;

    // accept-side decode
    logic              sid_ok_in;
    logic [HIDX_W-1:0] hidx_in;
    logic [PTR_W-1:0]  head_in;
    logic [PTR_W-1:0]  link_addr_in;

    // update-side decode
    logic [PTR_W-1:0] link_rd;
    logic [PTR_W-1:0] link_eff;
    logic             head_valid, free_valid;
    logic             do_push, do_pop, op_ok;
    logic [PTR_W-1:0] new_head;
    logic             link_wr_en;
    logic [PTR_W-1:0] link_wr_addr, link_wr_data;
    logic [VAL_W-1:0] value_rd;

    always_comb begin
        sid_ok_in = 32'(in_stack_id) < STACK_COUNT;
        hidx_in = sid_ok_in ? in_stack_id[HIDX_W-1:0] : '0;
        head_in = sid_ok_in ? heads_reg[hidx_in] : NULL_PTR;
        link_addr_in = (in_cmd == CMD_PUSH) ? free_head_reg : head_in;
    end

    always_comb begin
        link_eff = link_fresh_reg ? (link_addr_reg + PTR_W'(1)) : link_rd;
        head_valid = head_reg < NULL_PTR;
        free_valid = free_head_reg < NULL_PTR;
        do_push = sid_ok_reg && (op_reg == CMD_PUSH) && free_valid;
        do_pop = sid_ok_reg && (op_reg == CMD_POP) && head_valid;
        op_ok = do_push || do_pop || (sid_ok_reg && (op_reg == CMD_PEEK) && head_valid);

        new_head = head_reg;
        free_head_next = free_head_reg;
        if (do_push) begin
            new_head = free_head_reg;
            free_head_next = link_eff;
        end else if (do_pop) begin
            new_head = link_eff;
            free_head_next = head_reg;
        end

        fill_next = fill_reg;
        if (do_push && (free_head_reg == fill_reg)) begin
            fill_next = fill_reg + PTR_W'(1);
        end

        link_wr_en = ctrl.update && (do_push || do_pop);
        link_wr_addr = do_push ? free_head_reg : head_reg;
        link_wr_data = do_push ? head_reg : free_head_reg;
    end

    mss_ram #(
        .WIDTH (PTR_W),
        .DEPTH (SLOT_COUNT),
        .ADDR_W(ADDR_W)
    ) u_link_ram (
        .aclk   (aclk),
        .wr_en  (link_wr_en),
        .wr_addr(link_wr_addr[ADDR_W-1:0]),
        .wr_data(link_wr_data),
        .rd_en  (ctrl.accept),
        .rd_addr(link_addr_in[ADDR_W-1:0]),
        .rd_data(link_rd)
    );

    // a push answers with its own value, so its read of the slot being written is never used
    mss_ram #(
        .WIDTH (VAL_W),
        .DEPTH (SLOT_COUNT),
        .ADDR_W(ADDR_W)
    ) u_value_ram (
        .aclk   (aclk),
        .wr_en  (ctrl.update && do_push),
        .wr_addr(free_head_reg[ADDR_W-1:0]),
        .wr_data(val_reg),
        .rd_en  (ctrl.update),
        .rd_addr(new_head[ADDR_W-1:0]),
        .rd_data(value_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HEAD_DEPTH; i++) begin
                heads_reg[i] <= NULL_PTR;
            end
            free_head_reg <= '0;
            fill_reg <= '0;
        end else if (ctrl.update) begin
            if (do_push || do_pop) begin
                heads_reg[hidx_reg] <= new_head;
            end
            free_head_reg <= free_head_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.accept) begin
            op_reg <= in_cmd;
            sid_ok_reg <= sid_ok_in;
            hidx_reg <= hidx_in;
            val_reg <= in_push_value;
            head_reg <= head_in;
            link_addr_reg <= link_addr_in;
            link_fresh_reg <= link_addr_in >= fill_reg;
        end
        if (ctrl.update) begin
            ok_p_reg <= op_ok;
            empty_p_reg <= !(new_head < NULL_PTR);
            full_p_reg <= !(free_head_next < NULL_PTR);
            use_val_p_reg <= do_push;
        end
        if (ctrl.load_out) begin
            m_ok_reg <= ok_p_reg;
            m_empty_reg <= empty_p_reg;
            m_full_reg <= full_p_reg;
            if (empty_p_reg) begin
                m_top_reg <= '0;
            end else if (use_val_p_reg) begin
                m_top_reg <= val_reg;
            end else begin
                m_top_reg <= value_rd;
            end
        end
    end

    assign out_ok = m_ok_reg;
    assign out_top_value = m_top_reg;
    assign out_stack_empty = m_empty_reg;
    assign out_store_full = m_full_reg;

endmodule

@@ rtl/core/mss_ctrl.sv @@
// mss_ctrl: two-state operation sequencer and output handshake control
// depends on mss_pkg
`timescale 1ns / 1ps

module mss_ctrl import mss_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output mss_ctrl_t ctrl
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_UPDATE = 1'b1;

    logic state_reg, state_next;
    logic pend_reg, pend_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic out_free;

    always_comb begin
        out_free = !m_tvalid_reg || m_tready;
        ctrl.load_out = pend_reg && out_free;
        s_tready = (state_reg == ST_IDLE) && (!pend_reg || out_free);
        ctrl.accept = s_tvalid && s_tready;
        ctrl.update = state_reg == ST_UPDATE;

        case (state_reg)
            ST_IDLE:   state_next = ctrl.accept ? ST_UPDATE : ST_IDLE;
            ST_UPDATE: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase

        if (ctrl.update) begin
            pend_next = 1'b1;
        end else if (ctrl.load_out) begin
            pend_next = 1'b0;
        end else begin
            pend_next = pend_reg;
        end

        if (ctrl.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

`ifndef SYNTHESIS
    a_no_accept_in_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPDATE) |-> !s_tready)
        else $error("input accepted while an operation updates the lists");

    a_update_leaves_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPDATE) |=> (pend_reg && state_reg == ST_IDLE))
        else $error("update did not leave a pending result");

    a_pending_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg && !out_free) |-> !s_tready)
        else $error("new transfer taken while a result is stuck");

    a_load_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load_out |=> (m_tvalid_reg && !pend_reg))
        else $error("loaded result not presented");
`endif

endmodule

@@ rtl/core/multi_stack_shared_store_top.sv @@
// multi_stack_shared_store_top: usage notes
// s_ channel takes one operation per transfer: push, pop or peek on one of
//   the stacks; m_ channel returns exactly one result per operation, in order.
// every operation is read from the stack head flops and the link ram in the
//   accept cycle and applied in the next cycle; its result then waits in the
//   pending result register until the output register is free, is loaded there,
//   and m_tvalid rises with it.
// the next operation is not accepted until the current one has applied its list
//   update, which needs the dependent link ram read (registered) first.
// a finished result waits in the output register while the next operation is
//   accepted; with m_tready low and one more result pending, s_tready drops.
// reset (aresetn low, synchronous) empties all stacks and threads every slot
//   on the free list at once; untaken slots are tracked by a fill counter, so
//   there is no clearing pass and the block is ready the cycle after reset.
// depends on mss_pkg, mss_ctrl, mss_datapath, mss_ram
`timescale 1ns / 1ps

module multi_stack_shared_store_top import mss_pkg::*; #(
    parameter int SLOT_COUNT = 16,
    parameter int STACK_COUNT = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // cmd[1:0], stack_id[4:2], push_value[36:5], zeros above
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // ok[0], top_value[32:1], stack_empty[33], store_full[34], zeros above
    output logic [M_TDATA_W-1:0] m_tdata
);

    mss_ctrl_t               ctrl;
    logic                    out_ok;
    logic signed [VAL_W-1:0] out_top_value;
    logic                    out_stack_empty;
    logic                    out_store_full;

    mss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .ctrl    (ctrl)
    );

    mss_datapath #(
        .SLOT_COUNT (SLOT_COUNT),
        .STACK_COUNT(STACK_COUNT)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .in_cmd         (s_tdata[CMD_W-1:0]),
        .in_stack_id    (s_tdata[CMD_W+SID_W-1:CMD_W]),
        .in_push_value  (s_tdata[CMD_W+SID_W+VAL_W-1:CMD_W+SID_W]),
        .out_ok         (out_ok),
        .out_top_value  (out_top_value),
        .out_stack_empty(out_stack_empty),
        .out_store_full (out_store_full)
    );

    assign m_tdata = {{(M_TDATA_W - VAL_W - 3){1'b0}}, out_store_full, out_stack_empty,
                      out_top_value, out_ok};

endmodule
